// ----- sv/block_buffer_cache_lru_macros.svh -----
// assertion helpers shared by the rtl modules
`ifndef BLOCK_BUFFER_CACHE_LRU_MACROS_SVH
`define BLOCK_BUFFER_CACHE_LRU_MACROS_SVH

// checked on every clock edge outside reset
`define BBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define BBC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/bbc_pkg.sv -----
// ----------------------------------------------------------------------------
// bbc_pkg
// types and command/status structs of the lru block buffer cache
// ----------------------------------------------------------------------------
package bbc_pkg;

    typedef enum logic [1:0] {
        ACT_GET  = 2'd0,
        ACT_REL  = 2'd1,
        ACT_MARK = 2'd2,
        ACT_NONE = 2'd3
    } t_act;

    typedef enum logic [2:0] {
        KIND_HIT  = 3'd0,
        KIND_MISS = 3'd1,
        KIND_WB   = 3'd2,
        KIND_FULL = 3'd3,
        KIND_ACK  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_INC,
        PTR_HEAD,
        PTR_IDX
    } t_ptr_op;

    typedef enum logic [1:0] {
        ENT_PTR,
        ENT_SAVED,
        ENT_IDX,
        ENT_ZERO
    } t_ent_sel;

    typedef enum logic [1:0] {
        SRC_REQ,
        SRC_RDATA,
        SRC_SAVED,
        SRC_ZERO
    } t_src_sel;

    typedef struct packed {
        logic     latch_req;
        t_ptr_op  ptr_op;
        logic     unlink;
        logic     inc_use;
        logic     save_ent;
        logic     set_fdev;
        logic     fill;
        logic     release_op;
        logic     mark;
        logic     clr_dirty;
        logic     save_tag;
        logic     emit;
        t_kind    out_kind;
        t_ent_sel ent_sel;
        t_src_sel src_sel;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        t_act act;
        logic in_range;
        logic hit;
        logic fmatch;
        logic ptr_last;
        logic free_empty;
        logic head_dirty;
        logic rel_flush;
    } t_dp_sts;

endpackage

// ----- sv/bbc_req_if.sv -----
// ----------------------------------------------------------------------------
// bbc_req_if
// request channel of the block buffer cache
// ----------------------------------------------------------------------------
interface bbc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  device_id;
    logic [23:0] block_number;
    logic        is_vital;
    logic [4:0]  entry_index;

    modport source (
        output valid, action, device_id, block_number, is_vital, entry_index,
        input  ready
    );
    modport sink (
        input  valid, action, device_id, block_number, is_vital, entry_index,
        output ready
    );
endinterface

// ----- sv/bbc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bbc_rsp_if
// result channel of the block buffer cache
// ----------------------------------------------------------------------------
interface bbc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [4:0]  entry_id;
    logic [7:0]  out_device;
    logic [23:0] out_block;
    logic        last;

    modport source (
        output valid, kind, entry_id, out_device, out_block, last,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_id, out_device, out_block, last,
        output ready
    );
endinterface

// ----- sv/block_buffer_cache_lru.sv -----
// ----------------------------------------------------------------------------
// block_buffer_cache_lru: lru disk block buffer cache, one request at a time
// get: reads and compares each entry in turn, stops at the first hit; a miss
//   takes the free list head (full if none), flushing its device first if dirty
// release / mark dirty: read, update, flush when one is due, ack; stalls hold it
// reset clears flags and the free list at once, no clearing pass
// ----------------------------------------------------------------------------
module block_buffer_cache_lru #(
    parameter int ENTRIES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbc_req_if.sink   i_req,
    bbc_rsp_if.source o_rsp
);
    import bbc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    bbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bbc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_req.action),
        .i_device_id    (i_req.device_id),
        .i_block_number (i_req.block_number),
        .i_is_vital     (i_req.is_vital),
        .i_entry_index  (i_req.entry_index),
        .o_kind         (o_rsp.kind),
        .o_entry_id     (o_rsp.entry_id),
        .o_out_device   (o_rsp.out_device),
        .o_out_block    (o_rsp.out_block),
        .o_last         (o_rsp.last)
    );

endmodule

// ----- sv/bbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bbc_ctrl
// sequencer for lookup, eviction, device flush, release and mark dirty
// ----------------------------------------------------------------------------
`include "block_buffer_cache_lru_macros.svh"

module bbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output bbc_pkg::t_dp_cmd o_cmd,
    input  bbc_pkg::t_dp_sts i_sts
);
    import bbc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_G_RD,
        S_G_CMP,
        S_M_RD,
        S_M_CHK,
        S_M_FILL,
        S_F_RD,
        S_F_CMP,
        S_X_RD,
        S_X_OP,
        S_ACK
    } t_state;

    t_state  r_state, n_state;
    t_state  r_ret, n_ret;
    logic    r_out_valid, n_out_valid;
    logic    out_free;
    t_dp_cmd cmd;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_out_valid = r_out_valid && !i_out_ready;
        cmd         = '0;
        cmd.ptr_op  = PTR_HOLD;
        cmd.out_kind = KIND_ACK;
        cmd.ent_sel = ENT_ZERO;
        cmd.src_sel = SRC_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch_req = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.act == ACT_GET) begin
                    cmd.ptr_op = PTR_ZERO;
                    n_state = S_G_RD;
                end else if (i_sts.act == ACT_NONE || !i_sts.in_range) begin
                    n_state = S_ACK;
                end else begin
                    cmd.ptr_op = PTR_IDX;
                    n_state = S_X_RD;
                end
            end
            S_G_RD: n_state = S_G_CMP;
            S_G_CMP: begin
                if (i_sts.hit) begin
                    if (out_free) begin
                        cmd.unlink   = 1'b1;
                        cmd.inc_use  = 1'b1;
                        cmd.emit     = 1'b1;
                        cmd.out_kind = KIND_HIT;
                        cmd.ent_sel  = ENT_PTR;
                        cmd.src_sel  = SRC_REQ;
                        cmd.out_last = 1'b1;
                        n_out_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (i_sts.ptr_last) begin
                    if (i_sts.free_empty) begin
                        if (out_free) begin
                            cmd.emit     = 1'b1;
                            cmd.out_kind = KIND_FULL;
                            cmd.ent_sel  = ENT_ZERO;
                            cmd.src_sel  = SRC_REQ;
                            cmd.out_last = 1'b1;
                            n_out_valid  = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end else begin
                        cmd.ptr_op = PTR_HEAD;
                        n_state = S_M_RD;
                    end
                end else begin
                    cmd.ptr_op = PTR_INC;
                    n_state = S_G_RD;
                end
            end
            S_M_RD: n_state = S_M_CHK;
            S_M_CHK: begin
                cmd.unlink   = 1'b1;
                cmd.save_ent = 1'b1;
                cmd.set_fdev = 1'b1;
                if (i_sts.head_dirty) begin
                    cmd.ptr_op = PTR_ZERO;
                    n_ret   = S_M_FILL;
                    n_state = S_F_RD;
                end else begin
                    n_state = S_M_FILL;
                end
            end
            S_M_FILL: begin
                if (out_free) begin
                    cmd.fill     = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.out_kind = KIND_MISS;
                    cmd.ent_sel  = ENT_SAVED;
                    cmd.src_sel  = SRC_REQ;
                    cmd.out_last = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_F_RD: n_state = S_F_CMP;
            S_F_CMP: begin
                if (!i_sts.fmatch || out_free) begin
                    if (i_sts.fmatch) begin
                        cmd.clr_dirty = 1'b1;
                        cmd.emit      = 1'b1;
                        cmd.out_kind  = KIND_WB;
                        cmd.ent_sel   = ENT_PTR;
                        cmd.src_sel   = SRC_RDATA;
                        n_out_valid   = 1'b1;
                    end
                    if (i_sts.ptr_last) begin
                        n_state = r_ret;
                    end else begin
                        cmd.ptr_op = PTR_INC;
                        n_state = S_F_RD;
                    end
                end
            end
            S_X_RD: n_state = S_X_OP;
            S_X_OP: begin
                cmd.save_tag = 1'b1;
                n_state = S_ACK;
                if (i_sts.act == ACT_REL) begin
                    cmd.release_op = 1'b1;
                    if (i_sts.rel_flush) begin
                        cmd.set_fdev = 1'b1;
                        cmd.ptr_op   = PTR_ZERO;
                        n_ret   = S_ACK;
                        n_state = S_F_RD;
                    end
                end else begin
                    cmd.mark = 1'b1;
                end
            end
            S_ACK: begin
                if (out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.out_kind = KIND_ACK;
                    cmd.out_last = 1'b1;
                    if (i_sts.act == ACT_NONE) begin
                        cmd.ent_sel = ENT_ZERO;
                        cmd.src_sel = SRC_ZERO;
                    end else if (!i_sts.in_range) begin
                        cmd.ent_sel = ENT_IDX;
                        cmd.src_sel = SRC_ZERO;
                    end else begin
                        cmd.ent_sel = ENT_IDX;
                        cmd.src_sel = SRC_SAVED;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_out_valid <= n_out_valid;
        end
    end

    `BBC_ASSERT(a_emit_when_free, cmd.emit |-> out_free, "result loaded over a pending one")
    `BBC_ASSERT(a_accept_decodes, (i_in_valid && o_in_ready) |=> (r_state == S_DECODE),
        "accepted request not decoded")
    `BBC_ASSERT(a_last_ends, (cmd.emit && cmd.out_last) |=> (r_state == S_IDLE),
        "final result did not end the request")

endmodule

// ----- sv/bbc_datapath.sv -----
// ----------------------------------------------------------------------------
// bbc_datapath
// tag memory, entry flags, lru free list and result register
// ----------------------------------------------------------------------------
`include "block_buffer_cache_lru_macros.svh"

module bbc_datapath #(
    parameter int ENTRIES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bbc_pkg::t_dp_cmd i_cmd,
    output bbc_pkg::t_dp_sts o_sts,
    input  logic [1:0]       i_action,
    input  logic [7:0]       i_device_id,
    input  logic [23:0]      i_block_number,
    input  logic             i_is_vital,
    input  logic [4:0]       i_entry_index,
    output logic [2:0]       o_kind,
    output logic [4:0]       o_entry_id,
    output logic [7:0]       o_out_device,
    output logic [23:0]      o_out_block,
    output logic             o_last
);
    import bbc_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    logic [31:0]   mem [ENTRIES];
    logic [31:0]   r_rdata;
    logic [31:0]   r_sav;

    logic          r_valid [ENTRIES];
    logic [7:0]    r_use   [ENTRIES];
    logic          r_dirty [ENTRIES];
    logic          r_vital [ENTRIES];
    logic          r_inl   [ENTRIES];
    logic [IW-1:0] r_next  [ENTRIES];
    logic [IW-1:0] r_prev  [ENTRIES];
    logic [IW-1:0] r_head, r_tail;
    logic          r_empty;

    logic [IW-1:0] r_ptr, r_ent;
    logic [7:0]    r_fdev;

    t_act          r_act;
    logic [7:0]    r_dev;
    logic [23:0]   r_blk;
    logic          r_vit;
    logic [4:0]    r_eidx;

    logic [5:0]    idx6;
    logic [IW-1:0] idx;
    logic          in_range;
    logic [4:0]    ent_val;
    logic [31:0]   src_val;

    assign idx6     = {1'b0, r_eidx};
    assign in_range = idx6 < 6'(ENTRIES);
    assign idx      = idx6[IW-1:0];

    assign o_sts.act        = r_act;
    assign o_sts.in_range   = in_range;
    assign o_sts.hit        = r_valid[r_ptr] && (r_rdata == {r_dev, r_blk});
    assign o_sts.fmatch     = r_valid[r_ptr] && (r_rdata[31:24] == r_fdev);
    assign o_sts.ptr_last   = (r_ptr == IW'(ENTRIES - 1));
    assign o_sts.free_empty = r_empty;
    assign o_sts.head_dirty = r_valid[r_ptr] && r_dirty[r_ptr];
    assign o_sts.rel_flush  = (r_use[idx] == 8'd1) && r_valid[idx] && r_vital[idx]
                              && r_dirty[idx];

    // tag memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            mem[r_ent] <= {r_dev, r_blk};
        end
        r_rdata <= mem[r_ptr];
    end

    // request, pointers and saved values
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_req) begin
            r_act  <= t_act'(i_action);
            r_dev  <= i_device_id;
            r_blk  <= i_block_number;
            r_vit  <= i_is_vital;
            r_eidx <= i_entry_index;
        end
        case (i_cmd.ptr_op)
            PTR_ZERO: r_ptr <= '0;
            PTR_INC:  r_ptr <= r_ptr + IW'(1);
            PTR_HEAD: r_ptr <= r_head;
            PTR_IDX:  r_ptr <= idx;
            default:  r_ptr <= r_ptr;
        endcase
        if (i_cmd.save_ent) begin
            r_ent <= r_ptr;
        end
        if (i_cmd.set_fdev) begin
            r_fdev <= r_rdata[31:24];
        end
        if (i_cmd.save_tag) begin
            r_sav <= r_rdata;
        end
    end

    // entry flags and free list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_use[i]   <= '0;
                r_dirty[i] <= 1'b0;
                r_vital[i] <= 1'b0;
                r_inl[i]   <= 1'b1;
                r_next[i]  <= IW'((i + 1) % ENTRIES);
                r_prev[i]  <= IW'((i + ENTRIES - 1) % ENTRIES);
            end
            r_head  <= '0;
            r_tail  <= IW'(ENTRIES - 1);
            r_empty <= 1'b0;
        end else begin
            if (i_cmd.unlink && r_inl[r_ptr] && !r_empty) begin
                r_inl[r_ptr] <= 1'b0;
                if (r_head == r_ptr && r_tail == r_ptr) begin
                    r_empty <= 1'b1;
                end else if (r_head == r_ptr) begin
                    r_head <= r_next[r_ptr];
                end else if (r_tail == r_ptr) begin
                    r_tail <= r_prev[r_ptr];
                end else begin
                    r_next[r_prev[r_ptr]] <= r_next[r_ptr];
                    r_prev[r_next[r_ptr]] <= r_prev[r_ptr];
                end
            end
            if (i_cmd.inc_use && r_use[r_ptr] != 8'hff) begin
                r_use[r_ptr] <= r_use[r_ptr] + 8'd1;
            end
            if (i_cmd.fill) begin
                r_valid[r_ent] <= 1'b1;
                r_use[r_ent]   <= 8'd1;
                r_dirty[r_ent] <= 1'b0;
                r_vital[r_ent] <= r_vit;
            end
            if (i_cmd.clr_dirty) begin
                r_dirty[r_ptr] <= 1'b0;
            end
            if (i_cmd.mark && r_valid[idx]) begin
                r_dirty[idx] <= 1'b1;
            end
            if (i_cmd.release_op && r_use[idx] != 8'd0) begin
                r_use[idx] <= r_use[idx] - 8'd1;
                if (r_use[idx] == 8'd1 && !r_inl[idx]) begin
                    r_inl[idx] <= 1'b1;
                    if (r_empty) begin
                        r_head  <= idx;
                        r_tail  <= idx;
                        r_empty <= 1'b0;
                    end else begin
                        r_next[r_tail] <= idx;
                        r_prev[idx]    <= r_tail;
                        r_tail         <= idx;
                    end
                end
            end
        end
    end

    // result register
    always_comb begin
        case (i_cmd.ent_sel)
            ENT_PTR:   ent_val = 5'(r_ptr);
            ENT_SAVED: ent_val = 5'(r_ent);
            ENT_IDX:   ent_val = r_eidx;
            default:   ent_val = '0;
        endcase
        case (i_cmd.src_sel)
            SRC_REQ:   src_val = {r_dev, r_blk};
            SRC_RDATA: src_val = r_rdata;
            SRC_SAVED: src_val = r_valid[idx] ? r_sav : '0;
            default:   src_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_kind       <= i_cmd.out_kind;
            o_entry_id   <= ent_val;
            o_out_device <= src_val[31:24];
            o_out_block  <= src_val[23:0];
            o_last       <= i_cmd.out_last;
        end
    end

    `BBC_ASSERT(a_list_ends_linked, !r_empty |-> (r_inl[r_head] && r_inl[r_tail]),
        "free list head or tail not marked as listed")

endmodule
